### hw/rtl/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_CREATE  = 3'd1;
    localparam logic [2:0] FUNC_SUSPEND = 3'd2;
    localparam logic [2:0] FUNC_RESUME  = 3'd3;
    localparam logic [2:0] FUNC_DELETE  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_NULL   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  slot;
        logic [15:0] period;
        logic [15:0] init_delay;
        logic        has_action;
    } cmd_word_t;

    typedef struct packed {
        logic       dispatch_valid;
        logic [2:0] task_slot;
        logic [1:0] status;
        logic       last;
    } result_word_t;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] count;
        logic        suspend;
    } slot_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  func;
        logic [15:0] period;
        logic [15:0] init_delay;
        logic        has_action;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

### hw/rtl/ptts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_cell
// One task slot of the ring: holds period, countdown and suspend flag,
// shifts to its neighbor during a tick scan, applies commands when selected.
// ----------------------------------------------------------------------------
module ptts_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  ptts_pkg::slot_t   shift_in,
    input  ptts_pkg::cell_cmd_t cmd,
    input  logic              sel,
    output ptts_pkg::slot_t   cur,
    output logic [1:0]        status
);
    import ptts_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  in_use;

    assign in_use = (slot_reg.period != 16'd0);
    assign cur    = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        status    = ST_OK;
        if (shift)
        begin
            slot_next = shift_in;
        end
        else if (cmd.en && sel)
        begin
            case (cmd.func)
                FUNC_CREATE:
                begin
                    if (!cmd.has_action)
                    begin
                        status = ST_NULL;
                    end
                    else if (in_use)
                    begin
                        status = ST_BUSY;
                    end
                    else
                    begin
                        slot_next.period  = cmd.period;
                        slot_next.count   = cmd.init_delay;
                        slot_next.suspend = 1'b0;
                    end
                end
                FUNC_SUSPEND:
                begin
                    if (in_use)
                    begin
                        slot_next.suspend = 1'b1;
                    end
                    else
                    begin
                        status = ST_BUSY;
                    end
                end
                FUNC_RESUME:
                begin
                    slot_next.suspend = 1'b0;
                end
                FUNC_DELETE:
                begin
                    if (in_use)
                    begin
                        slot_next.period = 16'd0;
                    end
                    else
                    begin
                        status = ST_BUSY;
                    end
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

### hw/rtl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// A create, suspend, resume or delete word gives its status in the cycle after accept.
// A tick rotates the slot ring once, one slot per cycle, then passes a wrap-up state, staying
// busy throughout; a dispatch word waits for the next due slot or the wrap-up state.
// One command per cycle while not busy; a new tick is taken only once the block is idle again.
// Results cannot be stalled. Reset clears all slots to free and leaves the block idle.
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Ring of task slot cells; a tick rotates the ring past the head, where due
// slots are dispatched and reloaded and all others count down.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  ptts_pkg::cmd_word_t    cmd,
    output logic                   result_valid,
    output ptts_pkg::result_word_t result
);
    import ptts_pkg::*;

    localparam int STEP_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [3:0]          cnt_reg;
    logic [3:0]          cnt_next;
    logic [2:0]          hold_reg;
    logic [2:0]          hold_next;
    result_word_t        res_reg;
    result_word_t        res_next;
    logic                res_valid_reg;
    logic                res_valid_next;

    slot_t               cell_q   [TASK_SLOTS];
    logic [1:0]          cell_st  [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] sel;
    slot_t               head_upd;
    logic                head_due;
    cell_cmd_t           ccmd;
    logic                accept;
    logic                in_range;
    logic                shift;
    logic                step_end;
    logic [1:0]          cmd_status;
    logic [7:0]          step_idx;

    assign accept   = start && !busy;
    assign in_range = (cmd.slot < 8'(TASK_SLOTS));
    assign shift    = (state_reg == S_SCAN);
    assign step_end = (step_reg == STEP_W'(TASK_SLOTS - 1));
    assign step_idx = 8'(step_reg);

    assign ccmd.en          = accept && in_range && (cmd.func != FUNC_TICK);
    assign ccmd.func        = cmd.func;
    assign ccmd.period      = cmd.period;
    assign ccmd.init_delay  = cmd.init_delay;
    assign ccmd.has_action  = cmd.has_action;

    // head of the ring: dispatch check and countdown update
    assign head_due = (cell_q[0].count == 16'd0) && !cell_q[0].suspend
                      && (cell_q[0].period != 16'd0);

    always_comb
    begin
        head_upd = cell_q[0];
        if (head_due)
        begin
            head_upd.count = cell_q[0].period - 16'd1;
        end
        else
        begin
            head_upd.count = cell_q[0].count - 16'd1;
        end
    end

    for (genvar k = 0; k < TASK_SLOTS; k++)
    begin : g_cell
        slot_t nbr;
        if (k == TASK_SLOTS - 1)
        begin : g_tail
            assign nbr = head_upd;
        end
        else
        begin : g_mid
            assign nbr = cell_q[k+1];
        end

        assign sel[k] = (cmd.slot == 8'(k));

        ptts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .shift_in (nbr),
            .cmd      (ccmd),
            .sel      (sel[k]),
            .cur      (cell_q[k]),
            .status   (cell_st[k])
        );
    end

    always_comb
    begin
        cmd_status = ST_OK;
        for (int k = 0; k < TASK_SLOTS; k++)
        begin
            cmd_status = cmd_status | cell_st[k];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.func == FUNC_TICK))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (step_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_SCAN:  busy = 1'b1;
            S_DONE:  busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    // datapath: hold the latest dispatch so the final one can carry last
    always_comb
    begin
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        hold_next      = hold_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                cnt_next  = '0;
                if (accept && (cmd.func != FUNC_TICK))
                begin
                    res_valid_next          = 1'b1;
                    res_next.dispatch_valid = 1'b0;
                    res_next.task_slot      = 3'd0;
                    res_next.last           = 1'b1;
                    if (cmd.func > FUNC_DELETE)
                    begin
                        res_next.status = ST_OK;
                    end
                    else if (!in_range)
                    begin
                        res_next.status = ST_RANGE;
                    end
                    else
                    begin
                        res_next.status = cmd_status;
                    end
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (head_due && (cnt_reg < 4'(MAX_RESULTS)))
                begin
                    if (cnt_reg != 4'd0)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.dispatch_valid = 1'b1;
                        res_next.task_slot      = hold_reg;
                        res_next.status         = ST_OK;
                        res_next.last           = 1'b0;
                    end
                    hold_next = step_idx[2:0];
                    cnt_next  = cnt_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                res_valid_next          = 1'b1;
                res_next.dispatch_valid = (cnt_reg != 4'd0);
                res_next.task_slot      = (cnt_reg != 4'd0) ? hold_reg : 3'd0;
                res_next.status         = ST_OK;
                res_next.last           = 1'b1;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### hw/rtl/ptts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks on the scheduler's command and result words.
// ----------------------------------------------------------------------------
module ptts_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input ptts_pkg::cmd_word_t    cmd,
    input logic                   result_valid,
    input ptts_pkg::result_word_t result
);
    import ptts_pkg::*;

    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.func != FUNC_TICK)) |=>
            (result_valid && result.last && !result.dispatch_valid && !busy))
        else $error("command word did not give one final status word");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.func == FUNC_TICK)) |=> (busy && !result_valid))
        else $error("tick not scanning after accept");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-final word while idle");

    a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.dispatch_valid) |-> (result.status == ST_OK))
        else $error("dispatch word with nonzero status");

    a_nodispatch_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.dispatch_valid) |-> (result.task_slot == 3'd0))
        else $error("status word with nonzero task slot");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);
